/* rtl/xmkr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmkr_pkg
// Shared constants, types and the CRC-16 byte step for the XMODEM-1K receiver.
// ----------------------------------------------------------------------------
package xmkr_pkg;

  localparam int BLOCK_BYTES = 1024;
  localparam int ADDR_BITS   = 24;
  localparam int OFS_BITS    = $clog2(BLOCK_BYTES);
  localparam int QDEPTH      = 4;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = $clog2(QDEPTH + 1);

  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_EOT  = 8'h04;
  localparam logic [7:0] CH_ACK  = 8'h06;
  localparam logic [7:0] CH_NAK  = 8'h15;
  localparam logic [7:0] CH_CAN  = 8'h18;
  localparam logic [7:0] CH_POLL = 8'h43;

  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [3:0]  RETRY_RESET = 4'd10;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_TICK    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic CFG_DEST_BASE   = 1'b0;
  localparam logic CFG_RETRY_LIMIT = 1'b1;

  localparam logic [2:0] EXTRA_NONE   = 3'd0;
  localparam logic [2:0] EXTRA_ABORT  = 3'd3;
  localparam logic [2:0] EXTRA_NAKCAN = 3'd4;

  typedef enum logic [2:0] {
    PH_WAIT_FIRST = 3'd0,
    PH_WAIT_NEXT  = 3'd1,
    PH_BLKNUM     = 3'd2,
    PH_BLKCOMP    = 3'd3,
    PH_DATA       = 3'd4,
    PH_CRC_HI     = 3'd5,
    PH_CRC_LO     = 3'd6,
    PH_DONE       = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_EOT     = 2'd1,
    ST_CANCEL  = 2'd2,
    ST_ABORT   = 2'd3
  } status_t;

  typedef struct packed {
    logic                 wv;
    logic [ADDR_BITS-1:0] waddr;
    logic [7:0]           wdata;
    logic                 rv;
    logic [7:0]           rbyte;
    logic [2:0]           extra;
    status_t              status;
    logic [15:0]          packets;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/xmkr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmkr_front
// Protocol engine: takes one input transaction per cycle while accept is high, tracks the frame,
// writes data and computes CRC, and issues one command per transaction.
// ----------------------------------------------------------------------------
module xmkr_front
  import xmkr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic                 cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic                 accept,
  input  logic [1:0]           kind,
  input  logic [7:0]           rx_byte,
  output cmd_t                 cmd
);

  logic [23:0]          dest_base;
  logic [3:0]           retry_limit;

  phase_t               phase, phase_next;
  logic [7:0]           expected_block, expected_block_next;
  logic [15:0]          good_frames, good_frames_next;
  logic [3:0]           retries, retries_next;
  logic [OFS_BITS-1:0]  byte_offset, byte_offset_next;
  logic [15:0]          running_crc, running_crc_next;
  logic [ADDR_BITS-1:0] frame_base, frame_base_next;
  logic                 header_ok, header_ok_next;
  logic [7:0]           crc_high_seen, crc_high_seen_next;
  status_t              final_status, final_status_next;
  logic [4:0]           retry_count;
  logic                 frame_good;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_base   <= '0;
      retry_limit <= RETRY_RESET;
    end else if (cfg_wen) begin
      if (cfg_index == CFG_DEST_BASE) begin
        dest_base <= cfg_data;
      end else begin
        retry_limit <= cfg_data[3:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_WAIT_FIRST;
      expected_block <= 8'd1;
      good_frames    <= '0;
      retries        <= '0;
      byte_offset    <= '0;
      running_crc    <= '0;
      frame_base     <= '0;
      header_ok      <= 1'b0;
      crc_high_seen  <= '0;
      final_status   <= ST_RUNNING;
    end else if (accept) begin
      phase          <= phase_next;
      expected_block <= expected_block_next;
      good_frames    <= good_frames_next;
      retries        <= retries_next;
      byte_offset    <= byte_offset_next;
      running_crc    <= running_crc_next;
      frame_base     <= frame_base_next;
      header_ok      <= header_ok_next;
      crc_high_seen  <= crc_high_seen_next;
      final_status   <= final_status_next;
    end
  end

  assign retry_count = {1'b0, retries} + 5'd1;
  assign frame_good  = header_ok && (crc_high_seen == running_crc[15:8]) &&
                       (rx_byte == running_crc[7:0]);

  always_comb begin
    phase_next          = phase;
    expected_block_next = expected_block;
    good_frames_next    = good_frames;
    retries_next        = retries;
    byte_offset_next    = byte_offset;
    running_crc_next    = running_crc;
    frame_base_next     = frame_base;
    header_ok_next      = header_ok;
    crc_high_seen_next  = crc_high_seen;
    final_status_next   = final_status;
    cmd                 = '0;

    if (kind == KIND_RESTART) begin
      phase_next          = PH_WAIT_FIRST;
      expected_block_next = 8'd1;
      good_frames_next    = '0;
      retries_next        = '0;
      byte_offset_next    = '0;
      running_crc_next    = '0;
      frame_base_next     = dest_base[ADDR_BITS-1:0];
      header_ok_next      = 1'b0;
      crc_high_seen_next  = '0;
      final_status_next   = ST_RUNNING;
    end else if (kind == KIND_TICK) begin
      if (phase == PH_WAIT_FIRST) begin
        cmd.rv    = 1'b1;
        cmd.rbyte = CH_POLL;
      end
    end else if (kind == KIND_BYTE) begin
      unique case (phase)
        PH_WAIT_FIRST: begin
          if (rx_byte == CH_STX) begin
            frame_base_next    = dest_base[ADDR_BITS-1:0];
            phase_next         = PH_BLKNUM;
            byte_offset_next   = '0;
            running_crc_next   = '0;
            header_ok_next     = 1'b0;
            crc_high_seen_next = '0;
          end else begin
            cmd.rv    = 1'b1;
            cmd.rbyte = CH_POLL;
          end
        end
        PH_WAIT_NEXT: begin
          if (rx_byte == CH_STX) begin
            phase_next         = PH_BLKNUM;
            byte_offset_next   = '0;
            running_crc_next   = '0;
            header_ok_next     = 1'b0;
            crc_high_seen_next = '0;
          end else if (rx_byte == CH_EOT) begin
            cmd.rv            = 1'b1;
            cmd.rbyte         = CH_ACK;
            final_status_next = ST_EOT;
            phase_next        = PH_DONE;
          end else if (rx_byte == CH_CAN) begin
            final_status_next = ST_CANCEL;
            phase_next        = PH_DONE;
          end
        end
        PH_BLKNUM: begin
          if (rx_byte != expected_block) begin
            cmd.rv            = 1'b1;
            cmd.rbyte         = CH_CAN;
            cmd.extra         = EXTRA_ABORT;
            final_status_next = ST_ABORT;
            phase_next        = PH_DONE;
          end else begin
            phase_next = PH_BLKCOMP;
          end
        end
        PH_BLKCOMP: begin
          header_ok_next   = ((rx_byte ^ 8'hFF) == expected_block);
          byte_offset_next = '0;
          phase_next       = PH_DATA;
        end
        PH_DATA: begin
          cmd.wv           = 1'b1;
          cmd.waddr        = frame_base + ADDR_BITS'(byte_offset);
          cmd.wdata        = rx_byte;
          running_crc_next = crc16_byte(running_crc, rx_byte);
          if (byte_offset == OFS_BITS'(BLOCK_BYTES - 1)) begin
            byte_offset_next = '0;
            phase_next       = PH_CRC_HI;
          end else begin
            byte_offset_next = byte_offset + 1'b1;
          end
        end
        PH_CRC_HI: begin
          crc_high_seen_next = rx_byte;
          phase_next         = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          phase_next = PH_WAIT_NEXT;
          cmd.rv     = 1'b1;
          if (frame_good) begin
            cmd.rbyte           = CH_ACK;
            retries_next        = '0;
            frame_base_next     = frame_base + ADDR_BITS'(BLOCK_BYTES);
            expected_block_next = expected_block + 8'd1;
            good_frames_next    = good_frames + 16'd1;
          end else begin
            cmd.rbyte    = CH_NAK;
            retries_next = retry_count[4] ? 4'hF : retry_count[3:0];
            if (retry_count > {1'b0, retry_limit}) begin
              cmd.extra         = EXTRA_NAKCAN;
              final_status_next = ST_ABORT;
              phase_next        = PH_DONE;
            end
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    cmd.status  = final_status_next;
    cmd.packets = good_frames_next;
  end

endmodule

/* rtl/xmkr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmkr_queue
// Short command FIFO between the protocol engine and the result sequencer.
// ----------------------------------------------------------------------------
module xmkr_queue
  import xmkr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign full  = (count == QCNT_BITS'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full && !pop))
    else $error("queue push while full");

endmodule

/* rtl/xmkr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xmkr_back
// Result sequencer: expands each command into its result transactions and
// holds them in the output register until taken.
// ----------------------------------------------------------------------------
module xmkr_back
  import xmkr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 head,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 write_valid,
  output logic [ADDR_BITS-1:0] write_addr,
  output logic [7:0]           write_data,
  output logic                 reply_valid,
  output logic [7:0]           reply_byte,
  output logic [1:0]           status,
  output logic [15:0]          packets,
  output logic                 last
);

  logic [2:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !empty && (!out_valid || out_ready);
  assign at_last = (idx == head.extra);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_last ? 3'd0 : idx + 3'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (idx == 3'd0) begin
        write_valid <= head.wv;
        write_addr  <= head.waddr;
        write_data  <= head.wdata;
        reply_valid <= head.rv;
        reply_byte  <= head.rbyte;
      end else begin
        write_valid <= 1'b0;
        write_addr  <= '0;
        write_data  <= '0;
        reply_valid <= 1'b1;
        reply_byte  <= CH_CAN;
      end
      status  <= head.status;
      packets <= head.packets;
      last    <= at_last;
    end
  end

  a_mid_cmd_has_head: assert property (@(posedge clk) disable iff (rst)
    (idx != 3'd0) |-> !empty)
    else $error("sequencer lost its command mid-expansion");

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= EXTRA_NAKCAN)
    else $error("result index beyond longest command");

  a_write_no_reply: assert property (@(posedge clk) disable iff (rst)
    (out_valid && write_valid) |-> (!reply_valid && last))
    else $error("write result carries a reply or is not final");

endmodule

/* rtl/xmodem_1k_crc_receiver_core.sv */
`timescale 1ns / 1ps
// Results of an accepted transaction are registered in the command queue, then in the output register.
// One input per cycle while the queue is not full; the sequencer emits one result per cycle while out_ready is high.
// Commands that expand to 4 or 5 results (CAN abort) hold the sequencer until all are taken;
// a 4-entry command queue lets the front keep accepting meanwhile.
// Reset: synchronous, active high; clears the transfer, dest_base to 0, retry_limit to 10.
// ----------------------------------------------------------------------------
// xmodem_1k_crc_receiver_core
// XMODEM-1K CRC-16 receiver: protocol engine, command queue, result sequencer.
// ----------------------------------------------------------------------------
module xmodem_1k_crc_receiver_core
  import xmkr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic                 cfg_index,
  input  logic [23:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           kind,
  input  logic [7:0]           rx_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 write_valid,
  output logic [ADDR_BITS-1:0] write_addr,
  output logic [7:0]           write_data,
  output logic                 reply_valid,
  output logic [7:0]           reply_byte,
  output logic [1:0]           status,
  output logic [15:0]          packets,
  output logic                 last
);

  cmd_t front_cmd;
  cmd_t head;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  xmkr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (kind),
    .rx_byte   (rx_byte),
    .cmd       (front_cmd)
  );

  xmkr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  xmkr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (q_empty),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .write_valid (write_valid),
    .write_addr  (write_addr),
    .write_data  (write_data),
    .reply_valid (reply_valid),
    .reply_byte  (reply_byte),
    .status      (status),
    .packets     (packets),
    .last        (last)
  );

endmodule
